@@ hdl/nafd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package nafd_pkg;

	localparam int unsigned CMD_W = 4;
	localparam int unsigned DATA_WIDTH_DEF = 32;
	// Quotient bits resolved by one divider stage.
	localparam int unsigned DIV_BITS_PER_STAGE = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD  = 4'd0,
		CMD_SUB  = 4'd1,
		CMD_MUL  = 4'd2,
		CMD_DIV  = 4'd3,
		CMD_MOD  = 4'd4,
		CMD_EQ   = 4'd5,
		CMD_LT   = 4'd6,
		CMD_GT   = 4'd7,
		CMD_NE   = 4'd8,
		CMD_GE   = 4'd9,
		CMD_LE   = 4'd10,
		CMD_NEG  = 4'd11
	} nafd_cmd_t;

	// Control that rides along with an item through the divider stages.
	typedef struct packed {
		logic is_div;   // result comes from the divider
		logic is_mod;   // take the remainder rather than the quotient
		logic sign_a;   // dividend was negative
		logic sign_b;   // divisor was negative
	} nafd_ctl_t;

endpackage
`default_nettype wire

@@ hdl/nafd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface nafd_req_if #(parameter int unsigned DATA_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic [nafd_pkg::CMD_W-1:0]    cmd;
	logic signed [DATA_WIDTH-1:0]  left_operand;
	logic signed [DATA_WIDTH-1:0]  right_operand;

	modport source (output valid, cmd, left_operand, right_operand, input ready);
	modport sink   (input valid, cmd, left_operand, right_operand, output ready);
endinterface

interface nafd_rsp_if #(parameter int unsigned DATA_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic signed [DATA_WIDTH-1:0]  result_value;

	modport source (output valid, result_value, input ready);
	modport sink   (input valid, result_value, output ready);
endinterface
`default_nettype wire

@@ hdl/null_aware_floor_div_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload                                   | Handshake
// req     | in  | cmd, left_operand, right_operand          | valid / ready
// rsp     | out | result_value                              | valid / ready
//
// One transfer is accepted per cycle while the output is not held. The
// divider resolves four quotient bits per stage. All other commands ride
// the same pipeline so that results leave in order. Reset clears only the
// valid bits. When the output holds a result that is not taken, the whole
// pipeline holds and req.ready drops; nothing is lost or repeated.
module null_aware_floor_div_alu #(
	parameter int unsigned DATA_WIDTH = nafd_pkg::DATA_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nafd_req_if.sink   req,
	nafd_rsp_if.source rsp
);
	import nafd_pkg::*;

	localparam int unsigned NST = (DATA_WIDTH + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
	localparam logic [DATA_WIDTH-1:0] NULL_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// The pipeline advances whenever the output register is free or drains.
	logic en;
	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// ---------------- Stage 1: decode, simple operations, multiply ----------
	logic signed [DATA_WIDTH-1:0] a, b;
	logic                         a_null, b_null;
	logic [DATA_WIDTH-1:0]        res_c, amag, bmag;
	nafd_ctl_t                    ctl_c;

	assign a      = req.left_operand;
	assign b      = req.right_operand;
	assign a_null = (a == NULL_VAL);
	assign b_null = (b == NULL_VAL);
	assign amag   = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : a;
	assign bmag   = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : b;

	always_comb begin
		res_c        = '0;
		ctl_c.is_div = 1'b0;
		ctl_c.is_mod = 1'b0;
		ctl_c.sign_a = a[DATA_WIDTH-1];
		ctl_c.sign_b = b[DATA_WIDTH-1];
		unique case (nafd_cmd_t'(req.cmd))
			CMD_ADD, CMD_SUB, CMD_MUL: begin
				if (a_null) begin
					res_c = a;
				end else if (b_null) begin
					res_c = b;
				end else if (nafd_cmd_t'(req.cmd) == CMD_ADD) begin
					res_c = DATA_WIDTH'(a + b);
				end else if (nafd_cmd_t'(req.cmd) == CMD_SUB) begin
					res_c = DATA_WIDTH'(a - b);
				end else begin
					res_c = DATA_WIDTH'(a * b);
				end
			end
			CMD_DIV, CMD_MOD: begin
				// A null operand or a zero divisor short-circuits to null.
				res_c = NULL_VAL;
				if (!a_null && !b_null && (b != '0)) begin
					ctl_c.is_div = 1'b1;
					ctl_c.is_mod = (nafd_cmd_t'(req.cmd) == CMD_MOD);
				end
			end
			CMD_EQ:  res_c = DATA_WIDTH'(a == b);
			CMD_LT:  res_c = DATA_WIDTH'(a < b);
			CMD_GT:  res_c = DATA_WIDTH'(a > b);
			CMD_NE:  res_c = DATA_WIDTH'(a != b);
			CMD_GE:  res_c = DATA_WIDTH'(a >= b);
			CMD_LE:  res_c = DATA_WIDTH'(a <= b);
			CMD_NEG: res_c = a_null ? NULL_VAL : DATA_WIDTH'(-a);
			default: res_c = '0;
		endcase
	end

	logic                  v_s1;
	nafd_ctl_t             ctl_s1;
	logic [DATA_WIDTH-1:0] res_s1, dvs_s1, work_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_c;
			res_s1  <= res_c;
			dvs_s1  <= bmag;
			work_s1 <= amag;
		end
	end

	// ---------------- Divider stages on magnitudes --------------------------
	logic                  v_a    [NST+1];
	nafd_ctl_t             ctl_a  [NST+1];
	logic [DATA_WIDTH-1:0] res_a  [NST+1];
	logic [DATA_WIDTH-1:0] dvs_a  [NST+1];
	logic [DATA_WIDTH-1:0] rem_a  [NST+1];
	logic [DATA_WIDTH-1:0] work_a [NST+1];

	assign v_a[0]    = v_s1;
	assign ctl_a[0]  = ctl_s1;
	assign res_a[0]  = res_s1;
	assign dvs_a[0]  = dvs_s1;
	assign rem_a[0]  = '0;
	assign work_a[0] = work_s1;

	for (genvar k = 0; k < NST; k++) begin : g_div
		localparam int unsigned LEFT  = DATA_WIDTH - k * DIV_BITS_PER_STAGE;
		localparam int unsigned STEPS = (LEFT < DIV_BITS_PER_STAGE) ? LEFT : DIV_BITS_PER_STAGE;
		nafd_div_stage #(
			.DATA_WIDTH (DATA_WIDTH),
			.STEPS      (STEPS)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (v_a[k]),
			.ctl_i  (ctl_a[k]),
			.res_i  (res_a[k]),
			.dvs_i  (dvs_a[k]),
			.rem_i  (rem_a[k]),
			.work_i (work_a[k]),
			.v_o    (v_a[k+1]),
			.ctl_o  (ctl_a[k+1]),
			.res_o  (res_a[k+1]),
			.dvs_o  (dvs_a[k+1]),
			.rem_o  (rem_a[k+1]),
			.work_o (work_a[k+1])
		);
	end

	// ---------------- Final stage: floored sign fix-up ----------------------
	// When the operand signs differ and the remainder is nonzero, the
	// truncated quotient steps one further from zero and the remainder takes
	// the divisor's sign with magnitude |b| - |r|.
	nafd_ctl_t             ctl_f;
	logic [DATA_WIDTH-1:0] qmag, rmag, qmag_adj, rmag_adj, q_fl, r_fl, res_f;
	logic                  adjust;

	assign ctl_f    = ctl_a[NST];
	assign qmag     = work_a[NST];
	assign rmag     = rem_a[NST];
	assign adjust   = (ctl_f.sign_a != ctl_f.sign_b) && (rmag != '0);
	assign qmag_adj = qmag + DATA_WIDTH'(adjust);
	assign rmag_adj = adjust ? (dvs_a[NST] - rmag) : rmag;
	assign q_fl     = (ctl_f.sign_a != ctl_f.sign_b) ? DATA_WIDTH'(-qmag_adj) : qmag_adj;
	assign r_fl     = ctl_f.sign_b ? DATA_WIDTH'(-rmag_adj) : rmag_adj;
	assign res_f    = !ctl_f.is_div ? res_a[NST] : (ctl_f.is_mod ? r_fl : q_fl);

	logic                  v_q;
	logic [DATA_WIDTH-1:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_a[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_f;
		end
	end

	assign rsp.valid        = v_q;
	assign rsp.result_value = result_q;

	// ---------------- Assertions --------------------------------------------
	// The input side is held off only by an unaccepted result at the output.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("req.ready does not follow output backpressure");

	// An accepted request always lands in the first stage.
	a_enter_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> v_s1)
		else $error("accepted request missing from first stage");

	// A stalled pipeline keeps its last divider stage occupied.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_a[NST] && rsp.valid && !rsp.ready |=> v_a[NST])
		else $error("last divider stage lost an item during a stall");

endmodule
`default_nettype wire

@@ hdl/nafd_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
module nafd_div_stage #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned STEPS      = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  v_i,
	input  wire nafd_pkg::nafd_ctl_t   ctl_i,
	input  wire logic [DATA_WIDTH-1:0] res_i,
	input  wire logic [DATA_WIDTH-1:0] dvs_i,
	input  wire logic [DATA_WIDTH-1:0] rem_i,
	input  wire logic [DATA_WIDTH-1:0] work_i,
	output logic                       v_o,
	output nafd_pkg::nafd_ctl_t        ctl_o,
	output logic [DATA_WIDTH-1:0]      res_o,
	output logic [DATA_WIDTH-1:0]      dvs_o,
	output logic [DATA_WIDTH-1:0]      rem_o,
	output logic [DATA_WIDTH-1:0]      work_o
);
	import nafd_pkg::*;

	logic [DATA_WIDTH-1:0] rem_n;
	logic [DATA_WIDTH-1:0] work_n;

	// Restoring division: the dividend shifts out of the top of the work word
	// while quotient bits shift into its bottom.
	always_comb begin
		rem_n  = rem_i;
		work_n = work_i;
		for (int unsigned i = 0; i < STEPS; i++) begin
			rem_n  = {rem_n[DATA_WIDTH-2:0], work_n[DATA_WIDTH-1]};
			work_n = {work_n[DATA_WIDTH-2:0], 1'b0};
			if (rem_n >= dvs_i) begin
				rem_n     = rem_n - dvs_i;
				work_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_o  <= ctl_i;
			res_o  <= res_i;
			dvs_o  <= dvs_i;
			rem_o  <= rem_n;
			work_o <= work_n;
		end
	end

endmodule
`default_nettype wire

@@ dv/nafd_tb_if.sv @@
`timescale 1ns / 1ps
// The block's interfaces (nafd_req_if, nafd_rsp_if) come with the RTL.
// This file carries the one extra channel used only by the bench: a flag that
// the initial block raises once every pending item has been queued.
interface nafd_stim_done_if;
	logic done;

	modport source (output done);
	modport sink   (input done);
endinterface

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for null_aware_floor_div_alu.
//
// An initial block fills a queue of pending requests. It starts with a short
// directed set that covers the operand extremes, null operands, zero
// divisors, every command and the unused codes. Random requests follow.
// A clocked driver presents the requests with random gaps. Each accepted
// transfer is run through a local floored-division ALU model, and the result
// is queued. A clocked monitor takes the results with random stalls and
// compares each one with the oldest queued result.
//
// Early in the random part, the result side stops taking transfers for a long
// stretch while the driver keeps offering. This fills the pipeline and makes
// the block drop req.ready.
module testbench;
	import nafd_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int LATENCY = 2 + (DW + 3) / 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [DW-1:0] NULL_VAL = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic signed [DW-1:0] lhs;
		logic signed [DW-1:0] rhs;
	} alu_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nafd_req_if #(.DATA_WIDTH(DW)) req ();
	nafd_rsp_if #(.DATA_WIDTH(DW)) rsp ();
	nafd_stim_done_if stim ();

	null_aware_floor_div_alu #(.DATA_WIDTH(DW)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	alu_req_t pending_reqs[$];
	logic signed [DW-1:0] expected_results[$];
	int err_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int take_gap = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	int accepted = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// This model computes the floored quotient and remainder with 64-bit
	// signed arithmetic. The quotient rounds toward minus infinity, and the
	// remainder takes the sign of the divisor.
	function automatic logic signed [DW-1:0] alu_result(alu_req_t r);
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] q;
		logic signed [63:0] m;
		logic lnull;
		logic rnull;
		a = r.lhs;
		b = r.rhs;
		lnull = (r.lhs == NULL_VAL);
		rnull = (r.rhs == NULL_VAL);
		case (r.cmd)
			CMD_ADD, CMD_SUB, CMD_MUL: begin
				if (lnull)
					return NULL_VAL;
				if (rnull)
					return NULL_VAL;
				if (r.cmd == CMD_ADD)
					return r.lhs + r.rhs;
				if (r.cmd == CMD_SUB)
					return r.lhs - r.rhs;
				return r.lhs * r.rhs;
			end
			CMD_DIV, CMD_MOD: begin
				if (b == 0 || lnull || rnull)
					return NULL_VAL;
				q = a / b;
				m = a % b;
				if (m != 0 && ((m < 0) != (b < 0))) begin
					q = q - 1;
					m = m + b;
				end
				return (r.cmd == CMD_DIV) ? q[DW-1:0] : m[DW-1:0];
			end
			CMD_EQ: return (r.lhs == r.rhs) ? 1 : 0;
			CMD_LT: return (r.lhs < r.rhs) ? 1 : 0;
			CMD_GT: return (r.lhs > r.rhs) ? 1 : 0;
			CMD_NE: return (r.lhs != r.rhs) ? 1 : 0;
			CMD_GE: return (r.lhs >= r.rhs) ? 1 : 0;
			CMD_LE: return (r.lhs <= r.rhs) ? 1 : 0;
			CMD_NEG: return lnull ? NULL_VAL : -r.lhs;
			default: return '0;
		endcase
	endfunction

	// Operand values lean toward the edges: null, zero, small values,
	// the extremes, and sometimes a fully random word.
	function automatic logic signed [DW-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return NULL_VAL;
			1: return '0;
			2: return MAX_VAL;
			3: return NULL_VAL + 1;
			4, 5: return $signed($urandom_range(0, 40)) - 20;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		alu_req_t r;
		logic [CMD_W-1:0] c;
		logic signed [DW-1:0] edge_vals[6];
		edge_vals = '{NULL_VAL, NULL_VAL + 1, -1, 0, 1, MAX_VAL};
		stim.done = 1'b0;
		// These are the directed cases: every command, including the unused codes,
		// runs with two null operands, and the listed operand pairs follow.
		for (int k = 0; k < 16; k++) begin
			c = CMD_W'(k);
			pending_reqs.push_back('{c, NULL_VAL, NULL_VAL});
		end
		foreach (edge_vals[i])
			foreach (edge_vals[j])
				if ((i + j) % 3 == 0)
					pending_reqs.push_back('{CMD_DIV, edge_vals[i], edge_vals[j]});
		pending_reqs.push_back('{CMD_MOD, -7, 2});
		pending_reqs.push_back('{CMD_MOD, 7, -2});
		pending_reqs.push_back('{CMD_DIV, -7, 2});
		pending_reqs.push_back('{CMD_ADD, MAX_VAL, 1});
		pending_reqs.push_back('{CMD_MUL, 7, NULL_VAL});
		pending_reqs.push_back('{CMD_NEG, MAX_VAL, 0});
		for (int n = 0; n < 1130; n++) begin
			r.cmd = CMD_W'($urandom_range(0, 15));
			if ($urandom_range(0, 9) < 8)
				r.cmd = CMD_W'($urandom_range(0, 11));
			r.lhs = pick_operand();
			r.rhs = pick_operand();
			pending_reqs.push_back(r);
		end
		stim.done = 1'b1;
	end

	// The driver below sends the pending requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= '0;
			req.left_operand <= '0;
			req.right_operand <= '0;
			send_gap <= 0;
		end else begin
			if (req.valid && req.ready) begin
				expected_results.push_back(alu_result(
					'{req.cmd, req.left_operand, req.right_operand}));
				accepted <= accepted + 1;
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					req.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_reqs.size() > 0) begin
					alu_req_t nx;
					nx = pending_reqs.pop_front();
					req.valid <= 1'b1;
					req.cmd <= nx.cmd;
					req.left_operand <= nx.lhs;
					req.right_operand <= nx.rhs;
					send_gap <= pick_gap();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// The monitor below checks each result transfer. Once 60 requests have
	// been accepted, it holds off for a long stretch so that the pipeline
	// backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			take_gap <= 0;
			hold_cycles <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$error("result_value: expected none, actual %0d", rsp.result_value);
					err_count++;
				end else begin
					logic signed [DW-1:0] want;
					want = expected_results.pop_front();
					if (rsp.result_value !== want) begin
						$error("result_value: expected %0d, actual %0d", want,
							rsp.result_value);
						err_count++;
					end
				end
			end
			if (!hold_done && accepted >= 60) begin
				rsp.ready <= 1'b0;
				if (hold_cycles == 200)
					hold_done <= 1'b1;
				hold_cycles <= hold_cycles + 1;
			end else if (take_gap > 0) begin
				rsp.ready <= 1'b0;
				take_gap <= take_gap - 1;
			end else begin
				rsp.ready <= 1'b1;
				take_gap <= pick_gap();
			end
		end
	end

	// The run ends after all stimulus is sent and every result is checked.
	// A cycle limit guards against a hang.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (stim.done && pending_reqs.size() == 0 && !req.valid
					&& expected_results.size() == 0)
				break;
		end
		repeat (LATENCY + 60) @(posedge clk);
		if (err_count == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ filelist.f @@
hdl/nafd_pkg.sv
hdl/nafd_if.sv
hdl/nafd_div_stage.sv
hdl/null_aware_floor_div_alu.sv
dv/nafd_tb_if.sv
dv/testbench.sv
